>>> hdl/planar_point_transform_assert.svh
`ifndef PLANAR_POINT_TRANSFORM_ASSERT_SVH
`define PLANAR_POINT_TRANSFORM_ASSERT_SVH

// Check that the antecedent implies the consequent at every edge outside reset.
`define PPT_ASSERT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("planar_point_transform: implication violated");

// Check that a condition never holds at any edge outside reset.
`define PPT_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("planar_point_transform: forbidden condition seen");

`endif

>>> hdl/pptr_pkg.sv
package pptr_pkg;

	// Field widths
	localparam int COORD_WIDTH   = 32;
	localparam int ANGLE_WIDTH   = 16;
	localparam int CORDIC_STAGES = 16;

	// CORDIC internals
	localparam int GUARD_BITS        = 8;
	localparam int ATAN_ENTRIES      = 24;
	localparam int ATAN_INDEX_WIDTH  = 5;
	localparam int ATAN_WIDTH        = 32;
	localparam int GAIN_WIDTH        = 32;
	localparam logic [GAIN_WIDTH-1:0] INV_GAIN = 32'd2608131496;

	// Difference vector, one bit for the subtract and one for the later negate
	localparam int DIFF_WIDTH   = COORD_WIDTH + 2;
	// Rotating vector: difference, quadrant negate, guard bits and CORDIC growth
	localparam int VEC_WIDTH    = COORD_WIDTH + GUARD_BITS + 4;
	// Residual angle in units of one 2^32th of a turn, signed with headroom
	localparam int RESID_WIDTH  = ATAN_WIDTH + 2;
	// Rotated offset after gain, and the final sum with the reference
	localparam int ROT_WIDTH    = VEC_WIDTH - GUARD_BITS;
	localparam int SUM_WIDTH    = ROT_WIDTH + 1;

	// Commands
	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_TRANSLATE = 2'd0;
	localparam cmd_t CMD_ROTATE    = 2'd1;
	localparam cmd_t CMD_REFLECT   = 2'd2;
	localparam cmd_t CMD_MIRROR    = 2'd3;

	typedef struct packed {
		cmd_t                          command;
		logic signed [COORD_WIDTH-1:0] point_x;
		logic signed [COORD_WIDTH-1:0] point_y;
		logic signed [COORD_WIDTH-1:0] ref_x;
		logic signed [COORD_WIDTH-1:0] ref_y;
		logic [ANGLE_WIDTH-1:0]        turn_angle;
	} pptr_req_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] result_x;
		logic signed [COORD_WIDTH-1:0] result_y;
		logic                          saturated;
	} pptr_rsp_t;

	// Data that rides alongside the rotation
	typedef struct packed {
		logic                          rotated;
		logic signed [COORD_WIDTH-1:0] ref_x;
		logic signed [COORD_WIDTH-1:0] ref_y;
		logic signed [DIFF_WIDTH-1:0]  bypass_x;
		logic signed [DIFF_WIDTH-1:0]  bypass_y;
	} pptr_side_t;

	// One CORDIC beat: vector and residual angle
	typedef struct packed {
		logic signed [VEC_WIDTH-1:0]   x;
		logic signed [VEC_WIDTH-1:0]   y;
		logic signed [RESID_WIDTH-1:0] z;
	} pptr_vec_t;

	// atan(2^-i) in units of 2^-32 turn
	function automatic logic [ATAN_WIDTH-1:0] atan_turn(input logic [ATAN_INDEX_WIDTH-1:0] idx);
		logic [ATAN_WIDTH-1:0] a;
		case (idx)
			5'd0:    a = 32'h20000000;
			5'd1:    a = 32'h12E4051E;
			5'd2:    a = 32'h09FB385B;
			5'd3:    a = 32'h051111D4;
			5'd4:    a = 32'h028B0D43;
			5'd5:    a = 32'h0145D7E1;
			5'd6:    a = 32'h00A2F61E;
			5'd7:    a = 32'h00517C55;
			5'd8:    a = 32'h0028BE53;
			5'd9:    a = 32'h00145F2F;
			5'd10:   a = 32'h000A2F98;
			5'd11:   a = 32'h000517CC;
			5'd12:   a = 32'h00028BE6;
			5'd13:   a = 32'h000145F3;
			5'd14:   a = 32'h0000A2FA;
			5'd15:   a = 32'h0000517D;
			5'd16:   a = 32'h000028BE;
			5'd17:   a = 32'h0000145F;
			5'd18:   a = 32'h00000A30;
			5'd19:   a = 32'h00000518;
			5'd20:   a = 32'h0000028C;
			5'd21:   a = 32'h00000146;
			5'd22:   a = 32'h000000A3;
			5'd23:   a = 32'h00000051;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

>>> hdl/pptr_cordic.sv
`include "planar_point_transform_assert.svh"

module pptr_cordic #(
	parameter int STAGES = pptr_pkg::CORDIC_STAGES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  pptr_pkg::pptr_vec_t   in_vec,
	input  pptr_pkg::pptr_side_t  in_side,
	output logic                  out_valid,
	output pptr_pkg::pptr_vec_t   out_vec,
	output pptr_pkg::pptr_side_t  out_side
);

	// Stages past the end of the arctangent table do nothing
	localparam int USED = (STAGES < pptr_pkg::ATAN_ENTRIES) ? STAGES : pptr_pkg::ATAN_ENTRIES;
	localparam int VW = pptr_pkg::VEC_WIDTH;
	localparam int RW = pptr_pkg::RESID_WIDTH;
	localparam int AW = pptr_pkg::ATAN_WIDTH;
	// Residual bound after the last micro-rotation
	localparam logic signed [RW-1:0] Z_BOUND =
		$signed({1'b0, pptr_pkg::atan_turn(pptr_pkg::ATAN_INDEX_WIDTH'(USED - 1)), 1'b0});

	logic                 valid_s [1:USED];
	pptr_pkg::pptr_vec_t  vec_s   [1:USED];
	pptr_pkg::pptr_side_t side_s  [1:USED];

	for (genvar i = 0; i < USED; i++) begin : g_stage
		localparam logic [AW-1:0] STEP_ANGLE =
			pptr_pkg::atan_turn(pptr_pkg::ATAN_INDEX_WIDTH'(i));

		logic                 cur_valid;
		pptr_pkg::pptr_vec_t  cur_vec;
		pptr_pkg::pptr_side_t cur_side;
		pptr_pkg::pptr_vec_t  nxt_vec;
		logic signed [VW-1:0] cx, cy, sx, sy;
		logic signed [RW-1:0] cz, step;

		// Pick the beat entering this stage
		if (i == 0) begin : g_first
			assign cur_valid = in_valid;
			assign cur_vec   = in_vec;
			assign cur_side  = in_side;
		end else begin : g_next
			assign cur_valid = valid_s[i];
			assign cur_vec   = vec_s[i];
			assign cur_side  = side_s[i];
		end

		// Micro-rotate toward a zero residual; a zero residual turns forward
		always_comb begin
			cx   = cur_vec.x;
			cy   = cur_vec.y;
			cz   = cur_vec.z;
			sx   = cx >>> i;
			sy   = cy >>> i;
			step = $signed({{(RW - AW){1'b0}}, STEP_ANGLE});
			if (!cz[RW-1]) begin
				nxt_vec.x = cx - sy;
				nxt_vec.y = cy + sx;
				nxt_vec.z = cz - step;
			end else begin
				nxt_vec.x = cx + sy;
				nxt_vec.y = cy - sx;
				nxt_vec.z = cz + step;
			end
		end

		// Advance the valid bit
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i+1] <= 1'b0;
			end else begin
				valid_s[i+1] <= cur_valid;
			end
		end

		// Advance the payload
		always_ff @(posedge clk) begin
			vec_s[i+1]  <= nxt_vec;
			side_s[i+1] <= cur_side;
		end
	end

	assign out_valid = valid_s[USED];
	assign out_vec   = vec_s[USED];
	assign out_side  = side_s[USED];

	`PPT_ASSERT(a_cordic_latency, clk, arst_n, out_valid, $past(in_valid, USED))
	`PPT_ASSERT_NEVER(a_cordic_converged, clk, arst_n, out_valid && (out_vec.z > Z_BOUND || out_vec.z < -Z_BOUND))

endmodule

>>> hdl/planar_point_transform.sv
// Channel   Ports                    Handshake
// --------  -----------------------  ----------------------------------------
// request   start, busy, request     beat taken on an edge with start && !busy
// result    done, result             beat shown for one cycle while done is high
//
// One beat enters every cycle; busy never rises.
// Steps in order: input difference, quadrant turn, one micro-rotation per stage (capped at 24
// micro-rotations), magnitude, split gain multiply, rounding, and the final add with clipping.
// Reset clears the valid bits only; payload registers load every cycle.
// Nothing stalls: each result leaves straight from its last stage register.

`include "planar_point_transform_assert.svh"

module planar_point_transform #(
	parameter int CORDIC_STAGES = pptr_pkg::CORDIC_STAGES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  pptr_pkg::pptr_req_t request,
	output logic                busy,
	output logic                done,
	output pptr_pkg::pptr_rsp_t result
);

	localparam int CW = pptr_pkg::COORD_WIDTH;
	localparam int AW = pptr_pkg::ANGLE_WIDTH;
	localparam int DW = pptr_pkg::DIFF_WIDTH;
	localparam int VW = pptr_pkg::VEC_WIDTH;
	localparam int RW = pptr_pkg::RESID_WIDTH;
	localparam int GW = pptr_pkg::GAIN_WIDTH;
	localparam int GB = pptr_pkg::GUARD_BITS;
	localparam int ROTW = pptr_pkg::ROT_WIDTH;
	localparam int SW = pptr_pkg::SUM_WIDTH;
	localparam int MAG_WIDTH = VW - 1;
	localparam int LOW_BITS = MAG_WIDTH / 2;
	localparam int HIGH_BITS = MAG_WIDTH - LOW_BITS;
	localparam int PLO_WIDTH = LOW_BITS + GW;
	localparam int PHI_WIDTH = HIGH_BITS + GW;
	localparam int PROD_WIDTH = MAG_WIDTH + GW + 1;
	localparam int CORDIC_USED = (CORDIC_STAGES < pptr_pkg::ATAN_ENTRIES) ?
		CORDIC_STAGES : pptr_pkg::ATAN_ENTRIES;
	localparam int LATENCY = CORDIC_USED + 6;
	localparam logic [PROD_WIDTH-1:0] ROUND_HALF = PROD_WIDTH'(1) << (GW + GB - 1);
	localparam logic signed [SW-1:0] SUM_MAX = {{(SW - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
	localparam logic signed [SW-1:0] SUM_MIN = {{(SW - CW + 1){1'b1}}, {(CW - 1){1'b0}}};
	localparam logic signed [CW-1:0] OUT_MAX = {1'b0, {(CW - 1){1'b1}}};
	localparam logic signed [CW-1:0] OUT_MIN = {1'b1, {(CW - 1){1'b0}}};

	logic accept;

	logic                 valid_s1;
	logic signed [DW-1:0] dx_s1, dy_s1;
	logic [AW-1:0]        ang_s1;
	pptr_pkg::pptr_side_t side_s1;

	logic                 valid_s2;
	pptr_pkg::pptr_vec_t  vec_s2;
	pptr_pkg::pptr_side_t side_s2;

	logic                 cor_valid;
	pptr_pkg::pptr_vec_t  cor_vec;
	pptr_pkg::pptr_side_t cor_side;

	logic                 valid_s3;
	logic [MAG_WIDTH-1:0] mag_x_s3, mag_y_s3;
	logic                 neg_x_s3, neg_y_s3;
	pptr_pkg::pptr_side_t side_s3;

	logic                          valid_s4;
	logic [PLO_WIDTH-1:0]          plo_x_s4, plo_y_s4;
	logic [PHI_WIDTH-1:0]          phi_x_s4, phi_y_s4;
	logic                          neg_x_s4, neg_y_s4;
	pptr_pkg::pptr_side_t          side_s4;

	logic                 valid_s5;
	logic [ROTW-1:0]      rot_x_s5, rot_y_s5;
	logic                 neg_x_s5, neg_y_s5;
	pptr_pkg::pptr_side_t side_s5;

	logic                valid_s6;
	pptr_pkg::pptr_rsp_t result_s6;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Stage 1: difference to the reference and the exact bypass results
	logic signed [DW-1:0] px_e, py_e, rx_e, ry_e;
	logic                 is_mirror, is_translate;
	pptr_pkg::pptr_side_t side_d1;
	logic signed [DW-1:0] dy_d1;
	logic [AW-1:0]        ang_d1;

	always_comb begin
		px_e         = DW'(request.point_x);
		py_e         = DW'(request.point_y);
		rx_e         = DW'(request.ref_x);
		ry_e         = DW'(request.ref_y);
		is_mirror    = (request.command == pptr_pkg::CMD_MIRROR);
		is_translate = (request.command == pptr_pkg::CMD_TRANSLATE);
		// mirror works on the vector flipped across the x axis
		dy_d1  = is_mirror ? (ry_e - py_e) : (py_e - ry_e);
		ang_d1 = is_mirror ? {request.turn_angle[AW-2:0], 1'b0} : request.turn_angle;
		side_d1.rotated = (request.command == pptr_pkg::CMD_ROTATE) || is_mirror;
		side_d1.ref_x   = request.ref_x;
		side_d1.ref_y   = request.ref_y;
		side_d1.bypass_x = is_translate ? (px_e + rx_e) : ((rx_e <<< 1) - px_e);
		side_d1.bypass_y = is_translate ? (py_e + ry_e) : ((ry_e <<< 1) - py_e);
	end

	always_ff @(posedge clk) begin
		dx_s1   <= px_e - rx_e;
		dy_s1   <= dy_d1;
		ang_s1  <= ang_d1;
		side_s1 <= side_d1;
	end

	// Stage 2: quarter-turn by the top angle bits, add guard bits, seed residual
	logic signed [VW-1:0] ex, ey, qx, qy;
	pptr_pkg::pptr_vec_t  vec_d2;

	always_comb begin
		ex = VW'(dx_s1);
		ey = VW'(dy_s1);
		case (ang_s1[AW-1:AW-2])
			2'd1: begin
				qx = -ey;
				qy = ex;
			end
			2'd2: begin
				qx = -ex;
				qy = -ey;
			end
			2'd3: begin
				qx = ey;
				qy = -ex;
			end
			default: begin
				qx = ex;
				qy = ey;
			end
		endcase
		vec_d2.x = qx <<< GB;
		vec_d2.y = qy <<< GB;
		vec_d2.z = $signed(RW'({ang_s1[AW-3:0], {(pptr_pkg::ATAN_WIDTH - AW){1'b0}}}));
	end

	always_ff @(posedge clk) begin
		vec_s2  <= vec_d2;
		side_s2 <= side_s1;
	end

	// Micro-rotation pipeline
	pptr_cordic #(
		.STAGES(CORDIC_STAGES)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s2),
		.in_vec   (vec_s2),
		.in_side  (side_s2),
		.out_valid(cor_valid),
		.out_vec  (cor_vec),
		.out_side (cor_side)
	);

	// Stage 3: split each coordinate into sign and magnitude
	logic signed [VW-1:0] ax, ay, nx, ny;

	always_comb begin
		ax = cor_vec.x;
		ay = cor_vec.y;
		nx = -ax;
		ny = -ay;
	end

	always_ff @(posedge clk) begin
		neg_x_s3 <= ax[VW-1];
		neg_y_s3 <= ay[VW-1];
		mag_x_s3 <= ax[VW-1] ? nx[MAG_WIDTH-1:0] : ax[MAG_WIDTH-1:0];
		mag_y_s3 <= ay[VW-1] ? ny[MAG_WIDTH-1:0] : ay[MAG_WIDTH-1:0];
		side_s3  <= cor_side;
	end

	// Stage 4: partial products of the magnitude with the inverse gain
	always_ff @(posedge clk) begin
		plo_x_s4 <= PLO_WIDTH'(mag_x_s3[LOW_BITS-1:0]) * PLO_WIDTH'(pptr_pkg::INV_GAIN);
		plo_y_s4 <= PLO_WIDTH'(mag_y_s3[LOW_BITS-1:0]) * PLO_WIDTH'(pptr_pkg::INV_GAIN);
		phi_x_s4 <= PHI_WIDTH'(mag_x_s3[MAG_WIDTH-1:LOW_BITS]) * PHI_WIDTH'(pptr_pkg::INV_GAIN);
		phi_y_s4 <= PHI_WIDTH'(mag_y_s3[MAG_WIDTH-1:LOW_BITS]) * PHI_WIDTH'(pptr_pkg::INV_GAIN);
		neg_x_s4 <= neg_x_s3;
		neg_y_s4 <= neg_y_s3;
		side_s4  <= side_s3;
	end

	// Stage 5: join partials, round half up on the magnitude, drop gain and guard bits
	logic [PROD_WIDTH-1:0] tot_x, tot_y;

	always_comb begin
		tot_x = (PROD_WIDTH'(phi_x_s4) << LOW_BITS) + PROD_WIDTH'(plo_x_s4) + ROUND_HALF;
		tot_y = (PROD_WIDTH'(phi_y_s4) << LOW_BITS) + PROD_WIDTH'(plo_y_s4) + ROUND_HALF;
	end

	always_ff @(posedge clk) begin
		rot_x_s5 <= tot_x[GW+GB +: ROTW];
		rot_y_s5 <= tot_y[GW+GB +: ROTW];
		neg_x_s5 <= neg_x_s4;
		neg_y_s5 <= neg_y_s4;
		side_s5  <= side_s4;
	end

	// Stage 6: add back the reference, pick the bypass, clip to range
	logic signed [SW-1:0] ref_xe, ref_ye, rot_xe, rot_ye, sum_x, sum_y;
	logic                 hi_x, lo_x, hi_y, lo_y;
	pptr_pkg::pptr_rsp_t  rsp_d6;

	always_comb begin
		ref_xe = SW'(side_s5.ref_x);
		ref_ye = SW'(side_s5.ref_y);
		rot_xe = $signed(SW'(rot_x_s5));
		rot_ye = $signed(SW'(rot_y_s5));
		if (side_s5.rotated) begin
			sum_x = neg_x_s5 ? (ref_xe - rot_xe) : (ref_xe + rot_xe);
			sum_y = neg_y_s5 ? (ref_ye - rot_ye) : (ref_ye + rot_ye);
		end else begin
			sum_x = SW'(side_s5.bypass_x);
			sum_y = SW'(side_s5.bypass_y);
		end
		hi_x = (sum_x > SUM_MAX);
		lo_x = (sum_x < SUM_MIN);
		hi_y = (sum_y > SUM_MAX);
		lo_y = (sum_y < SUM_MIN);
		rsp_d6.result_x  = hi_x ? OUT_MAX : (lo_x ? OUT_MIN : sum_x[CW-1:0]);
		rsp_d6.result_y  = hi_y ? OUT_MAX : (lo_y ? OUT_MIN : sum_y[CW-1:0]);
		rsp_d6.saturated = hi_x || lo_x || hi_y || lo_y;
	end

	always_ff @(posedge clk) begin
		result_s6 <= rsp_d6;
	end

	// Advance valid bits alongside the beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= cor_valid;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	assign done   = valid_s6;
	assign result = result_s6;

	// Flags for the checks below
	logic x_railed, y_railed, mag_top;

	assign x_railed = (result.result_x == OUT_MAX) || (result.result_x == OUT_MIN);
	assign y_railed = (result.result_y == OUT_MAX) || (result.result_y == OUT_MIN);
	assign mag_top  = mag_x_s3[MAG_WIDTH-1] || mag_y_s3[MAG_WIDTH-1];

	`PPT_ASSERT(a_done_latency, clk, arst_n, done, $past(start && !busy, LATENCY))
	`PPT_ASSERT(a_sat_clipped, clk, arst_n, done && result.saturated, x_railed || y_railed)
	`PPT_ASSERT_NEVER(a_mag_headroom, clk, arst_n, valid_s3 && mag_top)

endmodule

>>> verif/point_transform_checker.sv
module point_transform_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  pptr_pkg::pptr_req_t request,
	input  logic                done,
	input  pptr_pkg::pptr_rsp_t result,
	output int                  pending,
	output int                  mismatches,
	output int                  results_seen,
	output int                  clipped_seen
);

	localparam int CW = pptr_pkg::COORD_WIDTH;
	localparam int AW = pptr_pkg::ANGLE_WIDTH;
	localparam int GB = pptr_pkg::GUARD_BITS;

	// Pair of wide coordinates carried through the rotation
	typedef struct packed {
		logic signed [63:0] x;
		logic signed [63:0] y;
	} wide_vec_t;

	// Arctangent of 2^-i in 2^-32 turn units, entry 0 at the right
	localparam logic [23:0][31:0] ARCTAN_STEP = {
		32'h00000051, 32'h000000A3, 32'h00000146, 32'h0000028C,
		32'h00000518, 32'h00000A30, 32'h0000145F, 32'h000028BE,
		32'h0000517D, 32'h0000A2FA, 32'h000145F3, 32'h00028BE6,
		32'h000517CC, 32'h000A2F98, 32'h00145F2F, 32'h0028BE53,
		32'h00517C55, 32'h00A2F61E, 32'h0145D7E1, 32'h028B0D43,
		32'h051111D4, 32'h09FB385B, 32'h12E4051E, 32'h20000000
	};

	pptr_pkg::pptr_rsp_t transformed_q [$];

	// Multiply by the inverse CORDIC gain, drop guard bits, round half away from zero
	function automatic longint unscale_gain(input longint v);
		logic          neg;
		logic [127:0]  mag;
		logic [127:0]  prod;
		longint        r;
		neg  = v < 0;
		mag  = {64'd0, (neg ? -v : v)};
		prod = mag * {96'd0, pptr_pkg::INV_GAIN} + (128'd1 << (31 + GB));
		prod = prod >> (32 + GB);
		r    = prod[63:0];
		return neg ? -r : r;
	endfunction

	// Rotate an offset counterclockwise by a fraction of a turn
	function automatic wide_vec_t rotate_offset(input wide_vec_t v,
			input logic [AW-1:0] ang);
		longint    x;
		longint    y;
		longint    z;
		longint    sx;
		longint    sy;
		wide_vec_t o;
		// coarse quarter turns, exact
		case (ang[AW-1 -: 2])
			2'd1: begin
				x = -v.y;
				y = v.x;
			end
			2'd2: begin
				x = -v.x;
				y = -v.y;
			end
			2'd3: begin
				x = v.y;
				y = -v.x;
			end
			default: begin
				x = v.x;
				y = v.y;
			end
		endcase
		z = longint'({48'd0, ang[AW-3:0]}) <<< (32 - AW);
		x = x * (64'sd1 <<< GB);
		y = y * (64'sd1 <<< GB);
		// micro-rotations, residual sign picks the direction
		for (int i = 0; i < pptr_pkg::CORDIC_STAGES && i < pptr_pkg::ATAN_ENTRIES; i++) begin
			sx = x >>> i;
			sy = y >>> i;
			if (z >= 0) begin
				x = x - sy;
				y = y + sx;
				z = z - longint'({32'd0, ARCTAN_STEP[i]});
			end else begin
				x = x + sy;
				y = y - sx;
				z = z + longint'({32'd0, ARCTAN_STEP[i]});
			end
		end
		o.x = unscale_gain(x);
		o.y = unscale_gain(y);
		return o;
	endfunction

	// Work out the transformed point for one request beat
	function automatic pptr_pkg::pptr_rsp_t transform_point(input pptr_pkg::pptr_req_t req);
		longint              px;
		longint              py;
		longint              rx;
		longint              ry;
		longint              ox;
		longint              oy;
		longint              maxv;
		longint              minv;
		logic [AW-1:0]       twice;
		wide_vec_t           d;
		pptr_pkg::pptr_rsp_t o;
		px     = req.point_x;
		py     = req.point_y;
		rx     = req.ref_x;
		ry     = req.ref_y;
		d.x    = px - rx;
		d.y    = py - ry;
		twice  = req.turn_angle << 1;
		case (req.command)
			pptr_pkg::CMD_TRANSLATE: begin
				ox = px + rx;
				oy = py + ry;
			end
			pptr_pkg::CMD_ROTATE: begin
				d  = rotate_offset(d, req.turn_angle);
				ox = rx + d.x;
				oy = ry + d.y;
			end
			pptr_pkg::CMD_REFLECT: begin
				ox = rx - d.x;
				oy = ry - d.y;
			end
			default: begin
				d.y = -d.y;
				d   = rotate_offset(d, twice);
				ox  = rx + d.x;
				oy  = ry + d.y;
			end
		endcase
		// clip to the coordinate range
		maxv        = (64'sd1 <<< (CW - 1)) - 1;
		minv        = -maxv - 1;
		o.saturated = 1'b0;
		if (ox > maxv) begin
			ox          = maxv;
			o.saturated = 1'b1;
		end else if (ox < minv) begin
			ox          = minv;
			o.saturated = 1'b1;
		end
		if (oy > maxv) begin
			oy          = maxv;
			o.saturated = 1'b1;
		end else if (oy < minv) begin
			oy          = minv;
			o.saturated = 1'b1;
		end
		o.result_x = ox[CW-1:0];
		o.result_y = oy[CW-1:0];
		return o;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
	endtask

	// Compare one result beat with the oldest expected point
	task automatic check_result(input pptr_pkg::pptr_rsp_t got);
		pptr_pkg::pptr_rsp_t want;
		results_seen++;
		if (got.saturated)
			clipped_seen++;
		if (transformed_q.size() == 0) begin
			report_mismatch("result beat with nothing expected, x", got.result_x, 0);
		end else begin
			want = transformed_q.pop_front();
			if (got.result_x !== want.result_x)
				report_mismatch("result_x", got.result_x, want.result_x);
			if (got.result_y !== want.result_y)
				report_mismatch("result_y", got.result_y, want.result_y);
			if (got.saturated !== want.saturated)
				report_mismatch("saturated", got.saturated, want.saturated);
		end
	endtask

	// Retire result beats first, then queue the prediction for a new request beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transformed_q.delete();
			pending      <= 0;
			mismatches   = 0;
			results_seen = 0;
			clipped_seen = 0;
		end else begin
			if (done)
				check_result(result);
			if (start && !busy)
				transformed_q.push_back(transform_point(request));
			pending <= transformed_q.size();
		end
	end

endmodule

>>> verif/tb_top.sv
module tb_top;

	localparam int CW = pptr_pkg::COORD_WIDTH;
	localparam int AW = pptr_pkg::ANGLE_WIDTH;

	localparam int RANDOM_BEATS = 1300;
	localparam int IDLE_LIMIT   = 400;
	localparam int SETTLE       = 30;

	localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	pptr_pkg::pptr_req_t request;
	logic                busy;
	logic                done;
	pptr_pkg::pptr_rsp_t result;

	int   pending;
	int   mismatches;
	int   results_seen;
	int   clipped_seen;
	int   idle_cycles = 0;
	int   beats_by_cmd [4];
	logic steady;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	planar_point_transform u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.busy    (busy),
		.done    (done),
		.result  (result)
	);

	point_transform_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.done         (done),
		.result       (result),
		.pending      (pending),
		.mismatches   (mismatches),
		.results_seen (results_seen),
		.clipped_seen (clipped_seen)
	);

	// Abort when nothing moves on either channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_top failed");
				$finish;
			end
		end
	end

	// Present one beat and hold it until taken
	task automatic send_point(input pptr_pkg::cmd_t cmd,
			input logic signed [CW-1:0] px, input logic signed [CW-1:0] py,
			input logic signed [CW-1:0] rx, input logic signed [CW-1:0] ry,
			input logic [AW-1:0] ang);
		pptr_pkg::pptr_req_t r;
		r.command    = cmd;
		r.point_x    = px;
		r.point_y    = py;
		r.ref_x      = rx;
		r.ref_y      = ry;
		r.turn_angle = ang;
		start   <= 1'b1;
		request <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		beats_by_cmd[cmd]++;
	endtask

	// Drop start for a random stretch, mostly short
	task automatic idle_gap();
		int pick;
		int n;
		pick = $urandom_range(0, 99);
		if (steady || pick < 55)
			n = 0;
		else if (pick < 90)
			n = $urandom_range(1, 3);
		else
			n = $urandom_range(5, 40);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Hold off until every expected point has come back
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [CW-1:0] pick_coord();
		int v;
		case ($urandom_range(0, 9))
			0, 1, 2: v = $urandom;
			3, 4, 5: v = int'($urandom_range(0, 2097151)) - 1048576;
			6: begin
				case ($urandom_range(0, 3))
					0:       v = CMAX;
					1:       v = CMIN;
					2:       v = 0;
					default: v = -1;
				endcase
			end
			default: v = int'($urandom_range(0, 536870911)) - 268435456;
		endcase
		return v;
	endfunction

	function automatic logic [AW-1:0] pick_angle();
		logic [AW-1:0] a;
		case ($urandom_range(0, 9))
			7: begin
				// near a quarter-turn boundary
				a = {2'($urandom_range(0, 3)), {(AW-2){1'b0}}};
				a = a + AW'($urandom_range(0, 4)) - AW'(2);
			end
			8: begin
				case ($urandom_range(0, 2))
					0:       a = '0;
					1:       a = '1;
					default: a = {1'b1, {(AW-1){1'b0}}};
				endcase
			end
			default: a = AW'($urandom_range(0, (1 << AW) - 1));
		endcase
		return a;
	endfunction

	// One random beat, usually a point close to its reference
	task automatic send_random();
		pptr_pkg::cmd_t        cmd;
		logic signed [CW-1:0]  rx;
		logic signed [CW-1:0]  ry;
		logic signed [CW-1:0]  px;
		logic signed [CW-1:0]  py;
		cmd = pptr_pkg::cmd_t'($urandom_range(0, 3));
		rx  = pick_coord();
		ry  = pick_coord();
		if ($urandom_range(0, 3) != 0) begin
			px = rx + (int'($urandom_range(0, 33554431)) - 16777216);
			py = ry + (int'($urandom_range(0, 33554431)) - 16777216);
		end else begin
			px = pick_coord();
			py = pick_coord();
		end
		send_point(cmd, px, py, rx, ry, pick_angle());
	endtask

	initial begin
		arst_n  = 1'b0;
		start   = 1'b0;
		request = '0;
		steady  = 1'b0;
		foreach (beats_by_cmd[i])
			beats_by_cmd[i] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// translate: zero, clipping both ways, edge just inside
		send_point(pptr_pkg::CMD_TRANSLATE, 0, 0, 0, 0, '0);
		send_point(pptr_pkg::CMD_TRANSLATE, CMAX, CMAX, CMAX, CMAX, '1);
		send_point(pptr_pkg::CMD_TRANSLATE, CMIN, CMIN, CMIN, CMIN, '0);
		send_point(pptr_pkg::CMD_TRANSLATE, CMAX, CMIN, -1, 0, 16'h1234);
		// reflection: negating the most negative value, far apart points
		send_point(pptr_pkg::CMD_REFLECT, CMIN, CMIN, 0, 0, '0);
		send_point(pptr_pkg::CMD_REFLECT, CMAX, CMAX, CMAX, CMAX, '1);
		send_point(pptr_pkg::CMD_REFLECT, CMIN, CMAX, CMAX, CMIN, 16'h8000);
		// rotation: zero angle, quarter turns, eighth, one unit, clipped far point
		send_point(pptr_pkg::CMD_ROTATE, 32'sh0003_0000, 32'sh0001_0000, 32'sh0001_0000, 0, '0);
		send_point(pptr_pkg::CMD_ROTATE, 32'sh0003_0000, 32'sh0001_0000, 32'sh0001_0000, 0,
			16'h4000);
		send_point(pptr_pkg::CMD_ROTATE, 32'sh0003_0000, 32'sh0001_0000, 32'sh0001_0000, 0,
			16'h8000);
		send_point(pptr_pkg::CMD_ROTATE, 32'sh0003_0000, 32'sh0001_0000, 32'sh0001_0000, 0,
			16'hC000);
		send_point(pptr_pkg::CMD_ROTATE, 32'sh0003_0000, 32'sh0001_0000, 32'sh0001_0000, 0, '1);
		send_point(pptr_pkg::CMD_ROTATE, -32'sh0002_8000, 32'sh0005_0000, 0, 0, 16'h2000);
		send_point(pptr_pkg::CMD_ROTATE, 32'sh0000_0001, 0, 0, 0, 16'h0001);
		send_point(pptr_pkg::CMD_ROTATE, CMIN, CMIN, CMAX, CMAX, 16'h2000);
		send_point(pptr_pkg::CMD_ROTATE, CMAX, CMIN, CMIN, CMAX, 16'h6000);
		// mirror: zero angle, half turn wrapping to zero, quarter, eighth, last unit
		send_point(pptr_pkg::CMD_MIRROR, 32'sh0004_0000, 32'sh0002_0000, 0, 32'sh0001_0000, '0);
		send_point(pptr_pkg::CMD_MIRROR, 32'sh0004_0000, 32'sh0002_0000, 0, 32'sh0001_0000,
			16'h8000);
		send_point(pptr_pkg::CMD_MIRROR, 32'sh0004_0000, 32'sh0002_0000, 0, 32'sh0001_0000,
			16'h4000);
		send_point(pptr_pkg::CMD_MIRROR, 32'sh0004_0000, 32'sh0002_0000, 0, 32'sh0001_0000,
			16'h2000);
		send_point(pptr_pkg::CMD_MIRROR, 32'sh0004_0000, 32'sh0002_0000, 0, 32'sh0001_0000, '1);
		send_point(pptr_pkg::CMD_MIRROR, 32'sh0004_0000, 32'sh0002_0000, 0, 32'sh0001_0000,
			16'hC000);
		send_point(pptr_pkg::CMD_MIRROR, CMAX, CMIN, CMIN, CMAX, 16'h1000);
		drain_results();

		// random beats, alternating bursts with and without gaps
		for (int k = 0; k < RANDOM_BEATS; k++) begin
			steady = ((k / 150) % 3) == 1;
			send_random();
			if (k % 400 == 399)
				drain_results();
			else
				idle_gap();
		end

		drain_results();
		repeat (SETTLE) @(posedge clk);
		$display("coverage: %0d beats sent (translate %0d, rotate %0d, reflect %0d, mirror %0d)",
			beats_by_cmd[0] + beats_by_cmd[1] + beats_by_cmd[2] + beats_by_cmd[3],
			beats_by_cmd[pptr_pkg::CMD_TRANSLATE], beats_by_cmd[pptr_pkg::CMD_ROTATE],
			beats_by_cmd[pptr_pkg::CMD_REFLECT], beats_by_cmd[pptr_pkg::CMD_MIRROR]);
		$display("coverage: %0d results checked, %0d of them clipped", results_seen, clipped_seen);
		if (mismatches == 0 && pending == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+hdl
hdl/pptr_pkg.sv
hdl/pptr_cordic.sv
hdl/planar_point_transform.sv
verif/point_transform_checker.sv
verif/tb_top.sv
